[rtl/bpfa_pkg.sv]
// Shared types and constants for the bitmap page frame allocator.
// Depends on nothing; used by the allocator top level.
`default_nettype none

package bpfa_pkg;

	localparam int FRAMES    = 65536;
	localparam int WORDS     = (FRAMES + 31) / 32;
	localparam int WORD_AW   = $clog2(WORDS);
	localparam int HINT_W    = $clog2(FRAMES + 1);
	localparam int TAIL_BITS = FRAMES % 32;
	localparam int CNT_W     = 17;
	localparam int FRAME_W   = 16;
	localparam int BMAP_W    = 32;

	localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

	typedef enum logic [1:0] {
		OP_FREE    = 2'd0,
		OP_LOCK    = 2'd1,
		OP_RESERVE = 2'd2,
		OP_REQUEST = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_DONE    = 2'd0,
		ST_ALREADY = 2'd1,
		ST_NO_MEM  = 2'd2,
		ST_RANGE   = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		S_CLEAR,
		S_IDLE,
		S_EXEC
	} state_t;

	typedef struct packed {
		op_t                op;
		logic [FRAME_W-1:0] frame;
	} cmd_t;

	typedef struct packed {
		status_t            status;
		logic [FRAME_W-1:0] result_frame;
		logic [CNT_W-1:0]   used_frames;
		logic [CNT_W-1:0]   reserved_frames;
		logic [CNT_W-1:0]   free_frames;
	} rsp_t;

endpackage

`default_nettype wire

[rtl/bitmap_page_frame_allocator_unit.sv]
// Bitmap page frame allocator top level: command decode, bitmap read-modify-write, scan.
// Depends on bpfa_pkg and bpfa_ram.
// After reset the unit sweeps the 2048-word bitmap to zero, one word a cycle, holding busy
// high for the whole sweep; configuration writes are taken during the sweep. A free, lock or
// reserve word reads its bitmap word, then modifies it and writes it back. A request scans
// N bitmap words from the hint (N from 1 to 2048), one word per cycle as the bitmap RAM
// gives them. The result is shown with done for one cycle right after the last cycle of the
// item, while the next word may already be started; the receiver cannot hold a result off.
`default_nettype none

module bitmap_page_frame_allocator_unit (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        start,
	input  wire bpfa_pkg::cmd_t              cmd,
	output logic                             busy,
	output logic                             done,
	output bpfa_pkg::rsp_t                   rsp,
	input  wire logic                        cfg_we,
	input  wire logic [bpfa_pkg::CNT_W-1:0]  cfg_wdata
);

	bpfa_pkg::state_t state_q, state_d;

	logic [bpfa_pkg::WORD_AW-1:0] clr_q, clr_d;
	logic [bpfa_pkg::WORD_AW-1:0] scan_q, scan_d;
	logic                         first_q, first_d;
	logic [bpfa_pkg::HINT_W-1:0]  hint_q, hint_d;
	logic [bpfa_pkg::CNT_W-1:0]   used_q, used_d;
	logic [bpfa_pkg::CNT_W-1:0]   resv_q, resv_d;
	logic [bpfa_pkg::CNT_W-1:0]   init_q;
	bpfa_pkg::op_t                op_q, op_d;
	logic [bpfa_pkg::FRAME_W-1:0] frame_q, frame_d;
	logic                         done_q, done_d;
	bpfa_pkg::status_t            status_q, status_d;
	logic [bpfa_pkg::FRAME_W-1:0] rframe_q, rframe_d;

	logic                         ram_we;
	logic [bpfa_pkg::WORD_AW-1:0] ram_waddr;
	logic [bpfa_pkg::BMAP_W-1:0]  ram_wdata;
	logic [bpfa_pkg::WORD_AW-1:0] ram_raddr;
	logic [bpfa_pkg::BMAP_W-1:0]  ram_rdata;

	logic [bpfa_pkg::BMAP_W-1:0]  avail;
	logic [bpfa_pkg::BMAP_W-1:0]  low_mask;
	logic [bpfa_pkg::BMAP_W-1:0]  bit_mask;
	logic [4:0]                   pos;
	logic                         found;
	logic [bpfa_pkg::CNT_W:0]     sum;

	bpfa_ram #(
		.WIDTH(bpfa_pkg::BMAP_W),
		.DEPTH(bpfa_pkg::WORDS)
	) u_bitmap (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// lowest free bit of the current scan word
	always_comb begin
		low_mask = first_q ? ((32'd1 << hint_q[4:0]) - 32'd1) : '0;
		avail    = ~ram_rdata & ~low_mask;
		if (bpfa_pkg::TAIL_BITS != 0 && 32'(scan_q) == 32'(bpfa_pkg::WORDS - 1)) begin
			avail = avail & ((32'd1 << bpfa_pkg::TAIL_BITS) - 32'd1);
		end
		found = |avail;
		pos   = '0;
		for (int i = bpfa_pkg::BMAP_W - 1; i >= 0; i--) begin
			if (avail[i]) begin
				pos = 5'(i);
			end
		end
	end

	always_comb begin
		state_d   = state_q;
		clr_d     = clr_q;
		scan_d    = scan_q;
		first_d   = first_q;
		hint_d    = hint_q;
		used_d    = used_q;
		resv_d    = resv_q;
		op_d      = op_q;
		frame_d   = frame_q;
		done_d    = 1'b0;
		status_d  = status_q;
		rframe_d  = rframe_q;
		ram_we    = 1'b0;
		ram_waddr = clr_q;
		ram_wdata = '0;
		ram_raddr = scan_q;
		bit_mask  = 32'd1 << frame_q[4:0];
		busy      = 1'b1;

		unique case (state_q)
			bpfa_pkg::S_CLEAR: begin
				ram_we = 1'b1;
				clr_d  = clr_q + bpfa_pkg::WORD_AW'(1);
				if (32'(clr_q) == 32'(bpfa_pkg::WORDS - 1)) begin
					state_d = bpfa_pkg::S_IDLE;
				end
			end
			bpfa_pkg::S_IDLE: begin
				busy = 1'b0;
				if (cmd.op == bpfa_pkg::OP_REQUEST) begin
					ram_raddr = bpfa_pkg::WORD_AW'(hint_q >> 5);
				end else begin
					ram_raddr = bpfa_pkg::WORD_AW'(cmd.frame >> 5);
				end
				if (start) begin
					op_d    = cmd.op;
					frame_d = cmd.frame;
					scan_d  = ram_raddr;
					first_d = 1'b1;
					state_d = bpfa_pkg::S_EXEC;
				end
			end
			bpfa_pkg::S_EXEC: begin
				ram_waddr = scan_q;
				rframe_d  = frame_q;
				status_d  = bpfa_pkg::ST_DONE;
				done_d    = 1'b1;
				state_d   = bpfa_pkg::S_IDLE;
				if (op_q == bpfa_pkg::OP_REQUEST) begin
					if (first_q && 32'(hint_q) >= bpfa_pkg::FRAMES) begin
						status_d = bpfa_pkg::ST_NO_MEM;
						rframe_d = '0;
					end else if (found) begin
						ram_we    = 1'b1;
						ram_wdata = ram_rdata | (32'd1 << pos);
						hint_d    = bpfa_pkg::HINT_W'({scan_q, pos});
						rframe_d  = bpfa_pkg::FRAME_W'({scan_q, pos});
						if (used_q != bpfa_pkg::CNT_MAX) begin
							used_d = used_q + bpfa_pkg::CNT_W'(1);
						end
					end else if (32'(scan_q) == 32'(bpfa_pkg::WORDS - 1)) begin
						hint_d   = bpfa_pkg::HINT_W'(bpfa_pkg::FRAMES);
						status_d = bpfa_pkg::ST_NO_MEM;
						rframe_d = '0;
					end else begin
						scan_d    = scan_q + bpfa_pkg::WORD_AW'(1);
						ram_raddr = scan_q + bpfa_pkg::WORD_AW'(1);
						first_d   = 1'b0;
						done_d    = 1'b0;
						state_d   = bpfa_pkg::S_EXEC;
					end
				end else if (32'(frame_q) >= bpfa_pkg::FRAMES) begin
					status_d = bpfa_pkg::ST_RANGE;
				end else if (op_q == bpfa_pkg::OP_FREE) begin
					if ((ram_rdata & bit_mask) == '0) begin
						status_d = bpfa_pkg::ST_ALREADY;
					end else begin
						ram_we    = 1'b1;
						ram_wdata = ram_rdata & ~bit_mask;
						if (used_q != '0) begin
							used_d = used_q - bpfa_pkg::CNT_W'(1);
						end
					end
				end else if ((ram_rdata & bit_mask) != '0) begin
					status_d = bpfa_pkg::ST_ALREADY;
				end else begin
					ram_we    = 1'b1;
					ram_wdata = ram_rdata | bit_mask;
					if (op_q == bpfa_pkg::OP_LOCK) begin
						if (used_q != bpfa_pkg::CNT_MAX) begin
							used_d = used_q + bpfa_pkg::CNT_W'(1);
						end
					end else begin
						if (resv_q != bpfa_pkg::CNT_MAX) begin
							resv_d = resv_q + bpfa_pkg::CNT_W'(1);
						end
						if (32'(hint_q) > 32'(frame_q)) begin
							hint_d = bpfa_pkg::HINT_W'(frame_q);
						end
					end
				end
			end
			default: begin
				state_d = bpfa_pkg::S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bpfa_pkg::S_CLEAR;
			clr_q   <= '0;
			first_q <= 1'b0;
			hint_q  <= '0;
			used_q  <= '0;
			resv_q  <= '0;
			init_q  <= '0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			clr_q   <= clr_d;
			first_q <= first_d;
			hint_q  <= hint_d;
			used_q  <= used_d;
			resv_q  <= resv_d;
			done_q  <= done_d;
			if (cfg_we) begin
				init_q <= cfg_wdata;
			end
		end
	end

	always_ff @(posedge clk) begin
		scan_q   <= scan_d;
		op_q     <= op_d;
		frame_q  <= frame_d;
		status_q <= status_d;
		rframe_q <= rframe_d;
	end

	// free count follows the held counters
	always_comb begin
		sum                 = {1'b0, used_q} + {1'b0, resv_q};
		rsp.status          = status_q;
		rsp.result_frame    = rframe_q;
		rsp.used_frames     = used_q;
		rsp.reserved_frames = resv_q;
		rsp.free_frames     = ({1'b0, init_q} > sum) ?
			bpfa_pkg::CNT_W'({1'b0, init_q} - sum) : '0;
	end

	assign done = done_q;

endmodule

`default_nettype wire

[rtl/bpfa_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`default_nettype none

module bpfa_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 2048
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

[test/frame_alloc_checker.sv]
// Checker for the bitmap page frame allocator: watches the command, response and
// configuration ports, predicts each response and compares it. Depends on bpfa_pkg.
module frame_alloc_checker
	import bpfa_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	input  wire cmd_t             cmd,
	input  wire logic             busy,
	input  wire logic             done,
	input  wire rsp_t             rsp,
	input  wire logic             cfg_we,
	input  wire logic [CNT_W-1:0] cfg_wdata,
	output int                    errors,
	output int                    pending
);

	bit                frame_used [FRAMES];
	logic [CNT_W-1:0]  used_cnt;
	logic [CNT_W-1:0]  rsvd_cnt;
	logic [CNT_W-1:0]  free_limit;
	logic [HINT_W-1:0] hint;
	rsp_t              owed_rsp_q [$];
	int                err_count = 0;

	assign errors = err_count;

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		$display("%0t: %s mismatch, got %0h want %0h", $time, what, got, want);
		err_count++;
	endtask

	function automatic rsp_t predict_response(input cmd_t c);
		rsp_t           r;
		int             f;
		logic [CNT_W:0] taken;
		r.status = ST_DONE;
		r.result_frame = c.frame;
		if (c.op == OP_REQUEST) begin
			f = int'(hint);
			while (f < FRAMES && frame_used[f])
				f++;
			hint = HINT_W'(f);
			if (f < FRAMES) begin
				frame_used[f] = 1'b1;
				if (used_cnt != CNT_MAX)
					used_cnt = used_cnt + CNT_W'(1);
				r.result_frame = FRAME_W'(f);
			end else begin
				r.status = ST_NO_MEM;
				r.result_frame = '0;
			end
		end else if (32'(c.frame) >= FRAMES) begin
			r.status = ST_RANGE;
		end else if (c.op == OP_FREE) begin
			if (!frame_used[c.frame]) begin
				r.status = ST_ALREADY;
			end else begin
				frame_used[c.frame] = 1'b0;
				if (used_cnt != '0)
					used_cnt = used_cnt - CNT_W'(1);
			end
		end else if (frame_used[c.frame]) begin
			r.status = ST_ALREADY;
		end else begin
			frame_used[c.frame] = 1'b1;
			if (c.op == OP_LOCK) begin
				if (used_cnt != CNT_MAX)
					used_cnt = used_cnt + CNT_W'(1);
			end else begin
				if (rsvd_cnt != CNT_MAX)
					rsvd_cnt = rsvd_cnt + CNT_W'(1);
				if (hint > HINT_W'(c.frame))
					hint = HINT_W'(c.frame);
			end
		end
		taken = {1'b0, used_cnt} + {1'b0, rsvd_cnt};
		r.used_frames = used_cnt;
		r.reserved_frames = rsvd_cnt;
		r.free_frames = ({1'b0, free_limit} > taken) ? CNT_W'({1'b0, free_limit} - taken) : '0;
		return r;
	endfunction

	always @(posedge clk) begin : watch
		rsp_t want;
		if (!arst_n) begin
			frame_used = '{default: 1'b0};
			used_cnt = '0;
			rsvd_cnt = '0;
			free_limit = '0;
			hint = '0;
			owed_rsp_q.delete();
		end else begin
			if (cfg_we)
				free_limit = cfg_wdata;
			if (done) begin
				if (owed_rsp_q.size() == 0) begin
					report_mismatch("unexpected word", 32'(rsp), '0);
				end else begin
					want = owed_rsp_q.pop_front();
					if (rsp.status !== want.status)
						report_mismatch("status", 32'(rsp.status), 32'(want.status));
					if (rsp.result_frame !== want.result_frame)
						report_mismatch("result_frame", 32'(rsp.result_frame),
							32'(want.result_frame));
					if (rsp.used_frames !== want.used_frames)
						report_mismatch("used_frames", 32'(rsp.used_frames),
							32'(want.used_frames));
					if (rsp.reserved_frames !== want.reserved_frames)
						report_mismatch("reserved_frames", 32'(rsp.reserved_frames),
							32'(want.reserved_frames));
					if (rsp.free_frames !== want.free_frames)
						report_mismatch("free_frames", 32'(rsp.free_frames),
							32'(want.free_frames));
				end
			end
			if (start && !busy)
				owed_rsp_q.push_back(predict_response(cmd));
		end
		pending <= owed_rsp_q.size();
	end

endmodule

[test/bitmap_page_frame_allocator_unit_test.sv]
// Testbench top for the bitmap page frame allocator: drives directed, random and
// request-run command streams and gives the verdict. Depends on bpfa_pkg,
// the allocator top level and frame_alloc_checker.
module bitmap_page_frame_allocator_unit_test;
	import bpfa_pkg::*;

	localparam int unsigned CYCLE_LIMIT = 10000000;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             start = 1'b0;
	cmd_t             cmd = '0;
	logic             cfg_we = 1'b0;
	logic [CNT_W-1:0] cfg_wdata = '0;
	logic             busy;
	logic             done;
	rsp_t             rsp;
	int               errors;
	int               pending;
	int unsigned      cycles = 0;
	int               burst_left = 0;

	bitmap_page_frame_allocator_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.cmd       (cmd),
		.busy      (busy),
		.done      (done),
		.rsp       (rsp),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	frame_alloc_checker alloc_check (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.cmd       (cmd),
		.busy      (busy),
		.done      (done),
		.rsp       (rsp),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.errors    (errors),
		.pending   (pending)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
	end

	initial begin
		wait (cycles >= CYCLE_LIMIT);
		$display("FAIL bitmap_page_frame_allocator_unit");
		$finish;
	end

	task automatic idle_for(input int n);
		start <= 1'b0;
		repeat (n) @(posedge clk);
	endtask

	task automatic send_word(input op_t op, input logic [FRAME_W-1:0] frame);
		cmd_t c;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 40);
			if ($urandom_range(0, 3) != 0)
				idle_for($urandom_range(1, 12));
		end
		burst_left--;
		c.op = op;
		c.frame = frame;
		start <= 1'b1;
		cmd <= c;
		do @(posedge clk); while (busy);
	endtask

	task automatic quiesce();
		start <= 1'b0;
		burst_left = 0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_free_limit(input logic [CNT_W-1:0] value);
		quiesce();
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic random_words(input int n);
		op_t                op;
		logic [FRAME_W-1:0] frame;
		int                 pick;
		repeat (n) begin
			pick = $urandom_range(0, 19);
			if (pick < 5)
				op = OP_FREE;
			else if (pick < 9)
				op = OP_LOCK;
			else if (pick < 13)
				op = OP_RESERVE;
			else
				op = OP_REQUEST;
			case ($urandom_range(0, 3))
				0, 1: frame = FRAME_W'($urandom_range(0, 127));
				2: frame = FRAME_W'($urandom_range(65408, 65535));
				default: frame = FRAME_W'($urandom);
			endcase
			if ($urandom_range(0, 99) == 0)
				quiesce();
			send_word(op, frame);
		end
	endtask

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		write_free_limit(CNT_W'(3));
		send_word(OP_RESERVE, 16'd100);
		send_word(OP_FREE, 16'd100);
		send_word(OP_REQUEST, 16'hFFFF);
		send_word(OP_REQUEST, 16'h0000);
		send_word(OP_LOCK, 16'd0);
		send_word(OP_FREE, 16'd0);
		send_word(OP_REQUEST, 16'h1234);
		send_word(OP_FREE, 16'd0);
		send_word(OP_RESERVE, 16'd0);
		send_word(OP_REQUEST, 16'd0);
		send_word(OP_FREE, 16'd0);
		send_word(OP_RESERVE, 16'hFFFF);
		send_word(OP_LOCK, 16'hFFFF);
		send_word(OP_FREE, 16'hFFFF);
		send_word(OP_LOCK, 16'hFFFF);
		send_word(OP_RESERVE, 16'h8000);
		send_word(OP_LOCK, 16'h5555);
		send_word(OP_LOCK, 16'hAAAA);
		send_word(OP_FREE, 16'h7FFF);
		send_word(OP_REQUEST, 16'hAAAA);

		write_free_limit(CNT_W'(65536));
		random_words(250);
		write_free_limit('0);
		random_words(250);
		write_free_limit(CNT_W'($urandom_range(0, 65536)));
		random_words(250);

		// run of requests that walks the hint across several bitmap words
		write_free_limit(CNT_W'(65536));
		repeat (80) send_word(OP_REQUEST, FRAME_W'($urandom));

		write_free_limit(CNT_W'($urandom_range(0, 65536)));
		random_words(100);

		quiesce();
		repeat (10) @(posedge clk);
		if (errors == 0)
			$display("PASS bitmap_page_frame_allocator_unit");
		else
			$display("FAIL bitmap_page_frame_allocator_unit");
		$finish;
	end

endmodule
